// ===== rtl/u16550_pkg.sv =====
`timescale 1ns / 1ps

package u16550_pkg;

    localparam int DEFAULT_FIFO_DEPTH = 16;
    localparam int DEFAULT_REG_STRIDE = 1;
    localparam int DATA_W             = 8;
    localparam int OFFSET_W           = 3;
    localparam int NUM_REGS           = 8;

    typedef enum logic [1:0] {
        REQ_READ    = 2'd0,
        REQ_WRITE   = 2'd1,
        REQ_RX_BYTE = 2'd2,
        REQ_TX_DONE = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        REG_RBR_THR = 3'd0,
        REG_IER     = 3'd1,
        REG_IIR_FCR = 3'd2,
        REG_LCR     = 3'd3,
        REG_MCR     = 3'd4,
        REG_LSR     = 3'd5,
        REG_MSR     = 3'd6,
        REG_SCR     = 3'd7
    } reg_idx_t;

    // bit positions
    localparam int LCR_DLAB_BIT   = 7;
    localparam int MCR_LOOP_BIT   = 4;
    localparam int IER_RDA_BIT    = 0;
    localparam int IER_THRE_BIT   = 1;
    localparam int IER_RLS_BIT    = 2;
    localparam int FCR_EN_BIT     = 0;
    localparam int FCR_CLR_RX_BIT = 1;
    localparam int FCR_CLR_TX_BIT = 2;

    localparam logic [7:0] LSR_DR    = 8'h01;
    localparam logic [7:0] LSR_OE    = 8'h02;
    localparam logic [7:0] LSR_ERRS  = 8'h1E;
    localparam logic [7:0] LSR_THRE  = 8'h20;
    localparam logic [7:0] LSR_TEMT  = 8'h40;
    localparam logic [7:0] FCR_MASK  = 8'hC1;
    localparam logic [3:0] IER_MASK  = 4'hF;
    localparam logic [7:0] MSR_IDLE  = 8'hB0;

    localparam logic [7:0] IIR_FIFO  = 8'hC0;
    localparam logic [7:0] IIR_RLS   = 8'h06;
    localparam logic [7:0] IIR_RDA   = 8'h04;
    localparam logic [7:0] IIR_THRE  = 8'h02;
    localparam logic [7:0] IIR_NONE  = 8'h01;

    // receive trigger levels selected by FCR[7:6]
    function automatic logic [3:0] trig_level(input logic [1:0] sel);
        logic [3:0] lvl;
        unique case (sel)
            2'd0:    lvl = 4'd1;
            2'd1:    lvl = 4'd4;
            2'd2:    lvl = 4'd8;
            default: lvl = 4'd14;
        endcase
        return lvl;
    endfunction

endpackage

// ===== rtl/u16550_fifo_ram.sv =====
`timescale 1ns / 1ps

module u16550_fifo_ram #(
    parameter int DEPTH  = u16550_pkg::DEFAULT_FIFO_DEPTH,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [u16550_pkg::DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [u16550_pkg::DATA_W-1:0] rd_data
);

    logic [u16550_pkg::DATA_W-1:0] mem [DEPTH];
    logic [u16550_pkg::DATA_W-1:0] rd_data_reg;

    // read data is registered; a write to the address being read is forwarded
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/uart_16550_registers.sv =====
`timescale 1ns / 1ps

// 16550-style UART register block.
// Slave stream: one transfer per request. tuser = req_type (0 read, 1 write,
// 2 line byte received, 3 transmit complete); tdata = reg_offset, data_in.
// Master stream: one transfer per request carrying read_data, tx_valid,
// tx_byte and tx_busy. Requests are answered strictly in order.
// cfg_valid/cfg_data write fifo_supported; cfg_ready is always high. Write it
// only while no request is in flight.
// Throughput: one request per cycle while the master side keeps accepting.
// A request sits in an input register, goes through a single stage of register
// logic and lands in an output register; the FIFO RAMs keep their head byte
// prefetched into read registers. If the master side stalls, the output
// register holds and the input register absorbs one more request before
// tready drops.
// Reset clears all UART registers, FIFO pointers and both streams, and sets
// fifo_supported to 1. FIFO contents are not cleared.
module uart_16550_registers #(
    parameter int FIFO_DEPTH = u16550_pkg::DEFAULT_FIFO_DEPTH,
    parameter int REG_STRIDE = u16550_pkg::DEFAULT_REG_STRIDE
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [2:0] reg_offset, [10:3] data_in, rest 0
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] read_data, [8] tx_valid,
                                        // [16:9] tx_byte, [17] tx_busy, rest 0
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // input register
    logic                     s_valid_reg;
    u16550_pkg::req_type_t    in_type_reg;
    logic [2:0]               in_off_reg;
    logic [7:0]               in_data_reg;
    logic                     proc_fire;

    // output register
    logic                     m_valid_reg;
    logic [7:0]               rd_out_reg;
    logic                     txv_out_reg;
    logic [7:0]               txb_out_reg;
    logic                     busy_out_reg;

    // UART state
    logic                     fifo_supported_reg;
    logic [CNT_W-1:0]         rx_count_reg,  rx_count_next;
    logic [PTR_W-1:0]         rx_head_reg,   rx_head_next;
    logic [CNT_W-1:0]         tx_count_reg,  tx_count_next;
    logic [PTR_W-1:0]         tx_head_reg,   tx_head_next;
    logic [7:0]               rx_holding_reg, rx_holding_next;
    logic                     rx_full_reg,   rx_full_next;
    logic [7:0]               error_bits_reg, error_bits_next;
    logic [3:0]               int_enable_reg, int_enable_next;
    logic [7:0]               fcr_reg,       fcr_next;
    logic [7:0]               lcr_reg,       lcr_next;
    logic [7:0]               mcr_reg,       mcr_next;
    logic [7:0]               dll_reg,       dll_next;
    logic [7:0]               dlm_reg,       dlm_next;
    logic [7:0]               scratch_reg,   scratch_next;
    logic [7:0]               shifter_reg,   shifter_next;
    logic                     busy_reg,      busy_next;
    logic                     thre_reg,      thre_next;

    // FIFO RAM ports
    logic                     rx_we, tx_we;
    logic [PTR_W-1:0]         rx_waddr, tx_waddr;
    logic [7:0]               rx_wdata, tx_wdata;
    logic [7:0]               rx_rd_data, tx_rd_data;

    // combinational results
    logic [7:0]               rd_val;
    logic                     txv_val;
    logic [7:0]               txb_val;

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] ofs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(ofs);
        if (sum >= SUM_W'(FIFO_DEPTH))
        begin
            sum = sum - SUM_W'(FIFO_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign proc_fire     = s_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s_valid_reg || proc_fire;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, busy_out_reg, txb_out_reg, txv_out_reg, rd_out_reg};

    u16550_fifo_ram #(
        .DEPTH  (FIFO_DEPTH),
        .ADDR_W (PTR_W)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_we),
        .wr_addr (rx_waddr),
        .wr_data (rx_wdata),
        .rd_addr (rx_head_next),
        .rd_data (rx_rd_data)
    );

    u16550_fifo_ram #(
        .DEPTH  (FIFO_DEPTH),
        .ADDR_W (PTR_W)
    ) u_tx_ram (
        .clk     (clk),
        .wr_en   (tx_we),
        .wr_addr (tx_waddr),
        .wr_data (tx_wdata),
        .rd_addr (tx_head_next),
        .rd_data (tx_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_type_reg <= u16550_pkg::req_type_t'(s_axis_tuser);
            in_off_reg  <= s_axis_tdata[2:0];
            in_data_reg <= s_axis_tdata[10:3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            rd_out_reg   <= rd_val;
            txv_out_reg  <= txv_val;
            txb_out_reg  <= txb_val;
            busy_out_reg <= busy_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_supported_reg <= 1'b1;
            rx_count_reg       <= '0;
            rx_head_reg        <= '0;
            tx_count_reg       <= '0;
            tx_head_reg        <= '0;
            rx_holding_reg     <= '0;
            rx_full_reg        <= 1'b0;
            error_bits_reg     <= '0;
            int_enable_reg     <= '0;
            fcr_reg            <= '0;
            lcr_reg            <= '0;
            mcr_reg            <= '0;
            dll_reg            <= '0;
            dlm_reg            <= '0;
            scratch_reg        <= '0;
            shifter_reg        <= '0;
            busy_reg           <= 1'b0;
            thre_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                fifo_supported_reg <= cfg_data;
            end
            rx_count_reg   <= rx_count_next;
            rx_head_reg    <= rx_head_next;
            tx_count_reg   <= tx_count_next;
            tx_head_reg    <= tx_head_next;
            rx_holding_reg <= rx_holding_next;
            rx_full_reg    <= rx_full_next;
            error_bits_reg <= error_bits_next;
            int_enable_reg <= int_enable_next;
            fcr_reg        <= fcr_next;
            lcr_reg        <= lcr_next;
            mcr_reg        <= mcr_next;
            dll_reg        <= dll_next;
            dlm_reg        <= dlm_next;
            scratch_reg    <= scratch_next;
            shifter_reg    <= shifter_next;
            busy_reg       <= busy_next;
            thre_reg       <= thre_next;
        end
    end

    always_comb
    begin
        logic                  fifo_on;
        logic                  fifo_now;
        logic                  rx_ready;
        logic                  dlab;
        logic [7:0]            lsr;
        logic [7:0]            msr;
        logic [7:0]            iir;
        logic [3:0]            lvl;
        logic [CNT_W-1:0]      trig;
        logic                  reg_hit;
        u16550_pkg::reg_idx_t  reg_sel;
        logic                  lr_do;
        logic [7:0]            lr_byte;
        logic                  st_do;
        logic [7:0]            head_byte;

        rx_count_next   = rx_count_reg;
        rx_head_next    = rx_head_reg;
        tx_count_next   = tx_count_reg;
        tx_head_next    = tx_head_reg;
        rx_holding_next = rx_holding_reg;
        rx_full_next    = rx_full_reg;
        error_bits_next = error_bits_reg;
        int_enable_next = int_enable_reg;
        fcr_next        = fcr_reg;
        lcr_next        = lcr_reg;
        mcr_next        = mcr_reg;
        dll_next        = dll_reg;
        dlm_next        = dlm_reg;
        scratch_next    = scratch_reg;
        shifter_next    = shifter_reg;
        busy_next       = busy_reg;
        thre_next       = thre_reg;
        rx_we           = 1'b0;
        rx_waddr        = rx_head_reg;
        rx_wdata        = in_data_reg;
        tx_we           = 1'b0;
        tx_waddr        = tx_head_reg;
        tx_wdata        = in_data_reg;
        rd_val          = '0;
        txv_val         = 1'b0;
        txb_val         = '0;
        lr_do           = 1'b0;
        lr_byte         = in_data_reg;
        st_do           = 1'b0;
        fifo_now        = 1'b0;

        fifo_on  = fifo_supported_reg && fcr_reg[u16550_pkg::FCR_EN_BIT];
        rx_ready = fifo_on ? (rx_count_reg != '0) : rx_full_reg;
        dlab     = lcr_reg[u16550_pkg::LCR_DLAB_BIT];

        lsr = error_bits_reg;
        if (rx_ready)
        begin
            lsr = lsr | u16550_pkg::LSR_DR;
        end
        if (tx_count_reg == '0)
        begin
            lsr = lsr | u16550_pkg::LSR_THRE;
            if (!busy_reg)
            begin
                lsr = lsr | u16550_pkg::LSR_TEMT;
            end
        end

        if (!mcr_reg[u16550_pkg::MCR_LOOP_BIT])
        begin
            msr = u16550_pkg::MSR_IDLE;
        end
        else
        begin
            msr = {mcr_reg[3], mcr_reg[2], mcr_reg[0], mcr_reg[1], 4'd0};
        end

        lvl = u16550_pkg::trig_level(fcr_reg[7:6]);
        if (int'(lvl) < FIFO_DEPTH)
        begin
            trig = CNT_W'(lvl);
        end
        else
        begin
            trig = CNT_W'(FIFO_DEPTH);
        end

        // offset decode: only multiples of the stride select a register
        reg_hit = 1'b0;
        reg_sel = u16550_pkg::REG_RBR_THR;
        for (int k = 0; k < u16550_pkg::NUM_REGS; k++)
        begin
            if ((k * REG_STRIDE < u16550_pkg::NUM_REGS) &&
                (in_off_reg == u16550_pkg::OFFSET_W'(k * REG_STRIDE)))
            begin
                reg_hit = 1'b1;
                reg_sel = u16550_pkg::reg_idx_t'(u16550_pkg::OFFSET_W'(k));
            end
        end

        iir = fifo_on ? u16550_pkg::IIR_FIFO : 8'd0;

        if (proc_fire)
        begin
            unique case (in_type_reg)
                u16550_pkg::REQ_READ:
                begin
                    if (reg_hit)
                    begin
                        unique case (reg_sel)
                            u16550_pkg::REG_RBR_THR:
                            begin
                                if (dlab)
                                begin
                                    rd_val = dll_reg;
                                end
                                else if (fifo_on)
                                begin
                                    if (rx_count_reg != '0)
                                    begin
                                        rd_val        = rx_rd_data;
                                        rx_head_next  = ptr_inc(rx_head_reg);
                                        rx_count_next = rx_count_reg - 1'b1;
                                    end
                                end
                                else if (rx_full_reg)
                                begin
                                    rd_val       = rx_holding_reg;
                                    rx_full_next = 1'b0;
                                end
                            end
                            u16550_pkg::REG_IER:
                            begin
                                rd_val = dlab ? dlm_reg : {4'd0, int_enable_reg};
                            end
                            u16550_pkg::REG_IIR_FCR:
                            begin
                                priority if (int_enable_reg[u16550_pkg::IER_RLS_BIT] &&
                                             ((lsr & u16550_pkg::LSR_ERRS) != 8'd0))
                                begin
                                    iir = iir | u16550_pkg::IIR_RLS;
                                end
                                else if (int_enable_reg[u16550_pkg::IER_RDA_BIT] && rx_ready &&
                                         (!fifo_on || rx_count_reg >= trig))
                                begin
                                    iir = iir | u16550_pkg::IIR_RDA;
                                end
                                else if (int_enable_reg[u16550_pkg::IER_THRE_BIT] && thre_reg)
                                begin
                                    iir       = iir | u16550_pkg::IIR_THRE;
                                    thre_next = 1'b0;
                                end
                                else
                                begin
                                    iir = iir | u16550_pkg::IIR_NONE;
                                end
                                rd_val = iir;
                            end
                            u16550_pkg::REG_LCR:
                            begin
                                rd_val = lcr_reg;
                            end
                            u16550_pkg::REG_MCR:
                            begin
                                rd_val = mcr_reg;
                            end
                            u16550_pkg::REG_LSR:
                            begin
                                rd_val          = lsr;
                                error_bits_next = error_bits_reg & ~u16550_pkg::LSR_ERRS;
                            end
                            u16550_pkg::REG_MSR:
                            begin
                                rd_val = msr;
                            end
                            u16550_pkg::REG_SCR:
                            begin
                                rd_val = scratch_reg;
                            end
                        endcase
                    end
                end
                u16550_pkg::REQ_WRITE:
                begin
                    if (reg_hit)
                    begin
                        unique case (reg_sel)
                            u16550_pkg::REG_RBR_THR:
                            begin
                                if (dlab)
                                begin
                                    dll_next = in_data_reg;
                                end
                                else
                                begin
                                    if (fifo_on)
                                    begin
                                        if (tx_count_reg < CNT_W'(FIFO_DEPTH))
                                        begin
                                            tx_we         = 1'b1;
                                            tx_waddr      = ptr_add(tx_head_reg, tx_count_reg);
                                            tx_count_next = tx_count_reg + 1'b1;
                                        end
                                    end
                                    else if (tx_count_reg == '0)
                                    begin
                                        tx_we         = 1'b1;
                                        tx_waddr      = tx_head_reg;
                                        tx_count_next = CNT_W'(1);
                                    end
                                    else
                                    begin
                                        // holding register occupied: overwrite newest byte
                                        tx_we    = 1'b1;
                                        tx_waddr = ptr_add(tx_head_reg,
                                                           CNT_W'(tx_count_reg - 1'b1));
                                    end
                                    thre_next = 1'b0;
                                    st_do     = 1'b1;
                                end
                            end
                            u16550_pkg::REG_IER:
                            begin
                                if (dlab)
                                begin
                                    dlm_next = in_data_reg;
                                end
                                else
                                begin
                                    int_enable_next = in_data_reg[3:0] & u16550_pkg::IER_MASK;
                                    if (!in_data_reg[u16550_pkg::IER_THRE_BIT])
                                    begin
                                        thre_next = 1'b0;
                                    end
                                    else if (!int_enable_reg[u16550_pkg::IER_THRE_BIT] &&
                                             (tx_count_reg == '0))
                                    begin
                                        thre_next = 1'b1;
                                    end
                                end
                            end
                            u16550_pkg::REG_IIR_FCR:
                            begin
                                fcr_next = fifo_supported_reg ?
                                           (in_data_reg & u16550_pkg::FCR_MASK) : 8'd0;
                                fifo_now = fifo_supported_reg &&
                                           fcr_next[u16550_pkg::FCR_EN_BIT];
                                if ((fifo_on != fifo_now) ||
                                    in_data_reg[u16550_pkg::FCR_CLR_RX_BIT])
                                begin
                                    rx_count_next   = '0;
                                    rx_head_next    = '0;
                                    rx_full_next    = 1'b0;
                                    error_bits_next = error_bits_reg & ~u16550_pkg::LSR_ERRS;
                                end
                                if ((fifo_on != fifo_now) ||
                                    in_data_reg[u16550_pkg::FCR_CLR_TX_BIT])
                                begin
                                    tx_count_next = '0;
                                    tx_head_next  = '0;
                                end
                                if (int_enable_reg[u16550_pkg::IER_THRE_BIT] &&
                                    (tx_count_next == '0))
                                begin
                                    thre_next = 1'b1;
                                end
                            end
                            u16550_pkg::REG_LCR:
                            begin
                                lcr_next = in_data_reg;
                            end
                            u16550_pkg::REG_MCR:
                            begin
                                mcr_next = in_data_reg;
                            end
                            u16550_pkg::REG_LSR,
                            u16550_pkg::REG_MSR:
                            begin
                            end
                            u16550_pkg::REG_SCR:
                            begin
                                scratch_next = in_data_reg;
                            end
                        endcase
                    end
                end
                u16550_pkg::REQ_RX_BYTE:
                begin
                    lr_do = 1'b1;
                end
                u16550_pkg::REQ_TX_DONE:
                begin
                    if (busy_reg)
                    begin
                        if (mcr_reg[u16550_pkg::MCR_LOOP_BIT])
                        begin
                            lr_do   = 1'b1;
                            lr_byte = shifter_reg;
                        end
                        else
                        begin
                            txv_val = 1'b1;
                            txb_val = shifter_reg;
                        end
                        busy_next = 1'b0;
                        st_do     = 1'b1;
                        if (int_enable_reg[u16550_pkg::IER_THRE_BIT] && (tx_count_reg == '0))
                        begin
                            thre_next = 1'b1;
                        end
                    end
                end
            endcase

            // load the shifter from the transmit head
            head_byte = (tx_we && (tx_waddr == tx_head_reg)) ? tx_wdata : tx_rd_data;
            if (st_do && !busy_next && (tx_count_next != '0))
            begin
                shifter_next  = head_byte;
                tx_head_next  = ptr_inc(tx_head_reg);
                tx_count_next = tx_count_next - 1'b1;
                busy_next     = 1'b1;
                if (int_enable_reg[u16550_pkg::IER_THRE_BIT] && (tx_count_next == '0))
                begin
                    thre_next = 1'b1;
                end
            end

            if (lr_do)
            begin
                if (fifo_on)
                begin
                    if (rx_count_reg >= CNT_W'(FIFO_DEPTH))
                    begin
                        error_bits_next = error_bits_reg | u16550_pkg::LSR_OE;
                    end
                    else
                    begin
                        rx_we         = 1'b1;
                        rx_waddr      = ptr_add(rx_head_reg, rx_count_reg);
                        rx_wdata      = lr_byte;
                        rx_count_next = rx_count_reg + 1'b1;
                    end
                end
                else if (rx_full_reg)
                begin
                    error_bits_next = error_bits_reg | u16550_pkg::LSR_OE;
                end
                else
                begin
                    rx_holding_next = lr_byte;
                    rx_full_next    = 1'b1;
                end
            end
        end
        else
        begin
            head_byte = tx_rd_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rx_count_reg <= CNT_W'(FIFO_DEPTH))
    else $error("receive count beyond FIFO depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (tx_count_reg <= CNT_W'(FIFO_DEPTH)) && (tx_head_reg <= PTR_W'(FIFO_DEPTH - 1)))
    else $error("transmit pointer state out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        thre_reg |-> int_enable_reg[u16550_pkg::IER_THRE_BIT])
    else $error("THRE interrupt pending with THRE interrupt disabled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid_reg && !proc_fire) |=> s_valid_reg)
    else $error("buffered request lost while output stalled");

endmodule
